[src/sacd_pkg.sv]
// Shared types, constants and defaults of the cache directory.
package sacd_pkg;

   localparam int ADDR_W       = 31;   // block address width
   localparam int WAY_OUT_W    = 2;    // width of the way field in a result
   localparam int REQ_DATA_W   = 32;   // {fill_dirty, block_address}
   localparam int RSP_DATA_W   = 40;   // 35 bits of fields, padded to bytes
   localparam int SETS_DEFAULT = 64;
   localparam int WAYS_DEFAULT = 4;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_FILL   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_UPDATE,
      ST_MUL,
      ST_OUT
   } state_type;

   // outcome of one set update
   typedef struct packed {
      logic hit;
      logic wb_valid;
   } upd_status_type;

endpackage

[src/sacd_divider.sv]
// Constant-divisor address split by reciprocal multiplication into tag and set.
module sacd_divider #(
   parameter int SETS = sacd_pkg::SETS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start_i,
   input  logic [sacd_pkg::ADDR_W-1:0]               dividend_i,
   output logic [sacd_pkg::ADDR_W-$clog2(SETS+1):0]  quotient_o,
   output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] remainder_o,
   output logic                                      done_o
);

   localparam int ADDR_W  = sacd_pkg::ADDR_W;
   localparam int TAG_W   = ADDR_W - $clog2(SETS + 1) + 1;
   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RECIP_W = ADDR_W + 1;
   localparam int PROD_W  = ADDR_W + RECIP_W;
   localparam int SHIFT   = ADDR_W + $clog2(SETS);
   // reciprocal rounded up: exact quotient for every ADDR_W-bit dividend
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << SHIFT) + longint'(SETS) - 1) / longint'(SETS));

   logic [ADDR_W-1:0] dvd_ff, dvd_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [TAG_W-1:0]  quo_ff, quo_in;
   logic [SET_W-1:0]  rem_ff, rem_in;
   logic              step_ff, step_in;
   logic              done_ff, done_in;
   logic [TAG_W-1:0]  quo_calc;
   logic [ADDR_W-1:0] back;

   // after the product register: quotient from the product, remainder by multiply-back
   assign quo_calc = TAG_W'(prod_ff >> SHIFT);
   assign back     = ADDR_W'(quo_calc) * ADDR_W'(SETS);

   always_comb begin
      dvd_in  = dvd_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = 1'b0;
      done_in = 1'b0;
      if (start_i) begin
         dvd_in  = dividend_i;
         prod_in = PROD_W'(dividend_i) * PROD_W'(RECIP);
         step_in = 1'b1;
      end
      if (step_ff) begin
         quo_in  = quo_calc;
         rem_in  = SET_W'(dvd_ff - back);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign quotient_o  = quo_ff;
   assign remainder_o = rem_ff;
   assign done_o      = done_ff;

endmodule

[src/sacd_dir_mem.sv]
// Directory row memory: one row per set, one write and one registered read port.
module sacd_dir_mem #(
   parameter int DEPTH  = sacd_pkg::SETS_DEFAULT,
   parameter int DATA_W = 8
) (
   input  logic                                        clock,
   input  logic                                        we_i,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
   input  logic [DATA_W-1:0]                           wdata_i,
   input  logic                                        re_i,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
   output logic [DATA_W-1:0]                           rdata_o
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we_i) begin
         mem[waddr_i] <= wdata_i;
      end
      if (re_i) begin
         rdata_ff <= mem[raddr_i];
      end
   end

   assign rdata_o = rdata_ff;

endmodule

[src/sacd_row_update.sv]
// Lookup and replacement on one set row: tag match, victim choice, LRU age update.
module sacd_row_update #(
   parameter int WAYS  = sacd_pkg::WAYS_DEFAULT,
   parameter int TAG_W = 25
) (
   input  logic                                                 kind_i,
   input  logic                                                 fill_dirty_i,
   input  logic [TAG_W-1:0]                                     tag_i,
   input  logic [WAYS-1:0]                                      valid_i,
   input  logic [WAYS-1:0]                                      dirty_i,
   input  logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] age_i,
   input  logic [WAYS-1:0][TAG_W-1:0]                           tags_i,
   output logic [WAYS-1:0]                                      valid_o,
   output logic [WAYS-1:0]                                      dirty_o,
   output logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] age_o,
   output logic [WAYS-1:0][TAG_W-1:0]                           tags_o,
   output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]           way_o,
   output logic [TAG_W-1:0]                                     victim_tag_o,
   output sacd_pkg::upd_status_type                             status_o
);

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_W = WAY_W;
   localparam int VCNT_W = $clog2(WAYS + 1);

   logic              hit_found, inv_found, old_found;
   logic [WAY_W-1:0]  hit_w, inv_w, old_w, chosen;
   logic [VCNT_W-1:0] cnt;
   logic              promote, new_way, set_dirty, write_tag, wb;
   logic [AGE_W-1:0]  old_age;

   // priority search, lowest way wins
   always_comb begin
      hit_found = 1'b0;
      inv_found = 1'b0;
      old_found = 1'b0;
      hit_w     = '0;
      inv_w     = '0;
      old_w     = '0;
      cnt       = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (valid_i[w] && (tags_i[w] == tag_i)) begin
            hit_found = 1'b1;
            hit_w     = WAY_W'(w);
         end
         if (!valid_i[w]) begin
            inv_found = 1'b1;
            inv_w     = WAY_W'(w);
         end
         if (age_i[w] == '0) begin
            old_found = 1'b1;
            old_w     = WAY_W'(w);
         end
         cnt = cnt + VCNT_W'(valid_i[w]);
      end
   end

   always_comb begin
      chosen    = '0;
      promote   = 1'b0;
      new_way   = 1'b0;
      set_dirty = 1'b0;
      write_tag = 1'b0;
      wb        = 1'b0;
      if (kind_i == sacd_pkg::KIND_LOOKUP) begin
         if (hit_found) begin
            chosen  = hit_w;
            promote = 1'b1;
         end
      end else if (hit_found) begin
         chosen    = hit_w;
         promote   = 1'b1;
         set_dirty = 1'b1;
      end else if (inv_found) begin
         chosen    = inv_w;
         new_way   = 1'b1;
         set_dirty = 1'b1;
         write_tag = 1'b1;
      end else begin
         // full set: evict the oldest way
         chosen    = old_found ? old_w : '0;
         promote   = 1'b1;
         set_dirty = 1'b1;
         write_tag = 1'b1;
         wb        = dirty_i[chosen];
      end
   end

   assign old_age = age_i[chosen];

   always_comb begin
      valid_o = valid_i;
      dirty_o = dirty_i;
      age_o   = age_i;
      tags_o  = tags_i;
      if (promote) begin
         for (int k = 0; k < WAYS; k++) begin
            if (valid_i[k] && (WAY_W'(k) != chosen) && (age_i[k] > old_age)) begin
               age_o[k] = age_i[k] - AGE_W'(1);
            end
         end
         age_o[chosen] = AGE_W'(cnt - VCNT_W'(1));
      end
      if (new_way) begin
         // count before the fill equals the new way's rank
         valid_o[chosen] = 1'b1;
         age_o[chosen]   = AGE_W'(cnt);
      end
      if (set_dirty) begin
         dirty_o[chosen] = fill_dirty_i;
      end
      if (write_tag) begin
         tags_o[chosen] = tag_i;
      end
   end

   assign way_o             = chosen;
   assign victim_tag_o      = tags_i[chosen];
   assign status_o.hit      = hit_found;
   assign status_o.wb_valid = wb;

endmodule

[src/set_assoc_cache_directory_lru.sv]
// Top level of the set-associative cache directory with counter-based LRU.
// Each request transaction carries a lookup or a fill of one block address and returns
// exactly one response transaction: hit, way, and for a fill that evicts a dirty line
// the victim's block address for write-back. The set is the address modulo SETS and the
// tag the quotient; the split multiplies by a rounded-up reciprocal of SETS and then
// multiplies back for the remainder. A transaction occupies the block from acceptance
// to the next possible acceptance (the divide step, then set read, set update and
// write-back, write-back address multiply, the output stage and the idle state that
// takes the next request). req_tready stays low meanwhile. The response sits in an
// output register, so a stalled response does not hold off the next request; only the
// output stage waits for it. After reset the directory runs a clearing pass over all
// SETS set rows, one set row per cycle, before the first request is accepted. LRU
// ages within a set are distinct, oldest is zero, and hits and fills become newest.
module set_assoc_cache_directory_lru #(
   parameter int SETS = sacd_pkg::SETS_DEFAULT,
   parameter int WAYS = sacd_pkg::WAYS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sacd_pkg::REQ_DATA_W-1:0]    req_tdata,  // block_address[30:0], fill_dirty[31]
   input  logic                               req_tuser,  // kind[0]: 0 lookup, 1 fill
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sacd_pkg::RSP_DATA_W-1:0]    rsp_tdata   // hit[0], way[2:1],
                                                          // writeback_valid[3],
                                                          // writeback_address[34:4], zero
);

   localparam int ADDR_W = sacd_pkg::ADDR_W;
   localparam int TAG_W  = ADDR_W - $clog2(SETS + 1) + 1;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_W  = WAY_W;
   localparam int ROW_W  = WAYS * (2 + AGE_W + TAG_W);
   localparam int PAD_W  = sacd_pkg::RSP_DATA_W - (ADDR_W + sacd_pkg::WAY_OUT_W + 2);

   sacd_pkg::state_type state_ff, state_in;

   // sequencer controls
   logic req_acc, div_start, mem_re, mem_we, upd_load, mul_load, out_load, clr_step;

   // clearing pass
   logic [SET_W-1:0] clr_ff, clr_in;

   // request latch
   logic kind_ff, fdirty_ff;

   // divider results
   logic [TAG_W-1:0] tag;
   logic [SET_W-1:0] set_idx;
   logic             div_done;

   // row memory
   logic [SET_W-1:0] mem_waddr;
   logic [ROW_W-1:0] mem_wdata, rd_row, new_row;

   logic [WAYS-1:0]             rd_valid, rd_dirty, nw_valid, nw_dirty;
   logic [WAYS-1:0][AGE_W-1:0]  rd_age, nw_age;
   logic [WAYS-1:0][TAG_W-1:0]  rd_tags, nw_tags;
   logic [WAY_W-1:0]            upd_way;
   logic [TAG_W-1:0]            upd_vtag;
   sacd_pkg::upd_status_type    upd_status;

   // result pipeline
   logic                 hit_ff, wb_ff;
   logic [WAY_W-1:0]     way_ff;
   logic [TAG_W-1:0]     vtag_ff;
   logic [ADDR_W-1:0]    prod_ff, wb_addr;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [sacd_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   assign req_acc = req_tvalid && req_tready;

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sacd_pkg::ST_CLEAR: begin
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = sacd_pkg::ST_IDLE;
            end
         end
         sacd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sacd_pkg::ST_DIV;
            end
         end
         sacd_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = sacd_pkg::ST_READ;
            end
         end
         sacd_pkg::ST_READ:   state_in = sacd_pkg::ST_UPDATE;
         sacd_pkg::ST_UPDATE: state_in = sacd_pkg::ST_MUL;
         sacd_pkg::ST_MUL:    state_in = sacd_pkg::ST_OUT;
         sacd_pkg::ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = sacd_pkg::ST_IDLE;
            end
         end
         default: state_in = sacd_pkg::ST_CLEAR;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      upd_load   = 1'b0;
      mul_load   = 1'b0;
      out_load   = 1'b0;
      clr_step   = 1'b0;
      case (state_ff)
         sacd_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            clr_step = 1'b1;
         end
         sacd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_tvalid;
         end
         sacd_pkg::ST_READ: mem_re = 1'b1;
         sacd_pkg::ST_UPDATE: begin
            mem_we   = 1'b1;
            upd_load = 1'b1;
         end
         sacd_pkg::ST_MUL: mul_load = 1'b1;
         sacd_pkg::ST_OUT: out_load = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      if (clr_step) begin
         clr_in = clr_ff + SET_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacd_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      if (req_acc) begin
         kind_ff   <= req_tuser;
         fdirty_ff <= req_tdata[ADDR_W];
      end
   end

   // ---------------- address split ----------------
   sacd_divider #(.SETS(SETS)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start_i     (div_start),
      .dividend_i  (req_tdata[ADDR_W-1:0]),
      .quotient_o  (tag),
      .remainder_o (set_idx),
      .done_o      (div_done)
   );

   // ---------------- set rows ----------------
   assign mem_waddr = (state_ff == sacd_pkg::ST_CLEAR) ? clr_ff : set_idx;
   assign mem_wdata = (state_ff == sacd_pkg::ST_CLEAR) ? '0 : new_row;

   sacd_dir_mem #(.DEPTH(SETS), .DATA_W(ROW_W)) u_mem (
      .clock   (clock),
      .we_i    (mem_we),
      .waddr_i (mem_waddr),
      .wdata_i (mem_wdata),
      .re_i    (mem_re),
      .raddr_i (set_idx),
      .rdata_o (rd_row)
   );

   // row layout: {tags, ages, dirty, valid}
   assign {rd_tags, rd_age, rd_dirty, rd_valid} = rd_row;
   assign new_row = {nw_tags, nw_age, nw_dirty, nw_valid};

   sacd_row_update #(.WAYS(WAYS), .TAG_W(TAG_W)) u_upd (
      .kind_i       (kind_ff),
      .fill_dirty_i (fdirty_ff),
      .tag_i        (tag),
      .valid_i      (rd_valid),
      .dirty_i      (rd_dirty),
      .age_i        (rd_age),
      .tags_i       (rd_tags),
      .valid_o      (nw_valid),
      .dirty_o      (nw_dirty),
      .age_o        (nw_age),
      .tags_o       (nw_tags),
      .way_o        (upd_way),
      .victim_tag_o (upd_vtag),
      .status_o     (upd_status)
   );

   // ---------------- result path ----------------
   // victim address = tag * SETS + set, always below 2^31
   assign wb_addr = wb_ff ? (prod_ff + ADDR_W'(set_idx)) : '0;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (upd_load) begin
         hit_ff  <= upd_status.hit;
         wb_ff   <= upd_status.wb_valid;
         way_ff  <= upd_way;
         vtag_ff <= upd_vtag;
      end
      if (mul_load) begin
         prod_ff <= ADDR_W'(ADDR_W'(vtag_ff) * ADDR_W'(SETS));
      end
      if (out_load) begin
         rsp_tdata_ff <= {PAD_W'(0), wb_addr, wb_ff,
                          sacd_pkg::WAY_OUT_W'(way_ff), hit_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------- assertions ----------------
   // one transaction at a time: accepting closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request accepted while a transaction is in flight");

   // write-back only comes from an eviction, never with a hit
   a_wb_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> !rsp_tdata[0])
      else $error("write-back reported together with a hit");

   // the divider finishes only while the sequencer waits for it
   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == sacd_pkg::ST_DIV))
      else $error("divider finished outside the divide step");

endmodule

[tb/sv/directory_shadow_pkg.sv]
// Shadow copy of the cache directory that predicts and checks its response transactions.
package directory_shadow_pkg;

   import sacd_pkg::*;

   localparam int SETS = SETS_DEFAULT;
   localparam int WAYS = WAYS_DEFAULT;

   class directory_shadow;

      typedef struct {
         logic [ADDR_W-1:0]    req_addr;   // for diagnostics only
         bit                   hit;
         bit [WAY_OUT_W-1:0]   way;
         bit                   wb_valid;
         bit [ADDR_W-1:0]      wb_addr;
      } dir_result_t;

      bit          line_valid [SETS][WAYS];
      bit          line_dirty [SETS][WAYS];
      int unsigned line_tag   [SETS][WAYS];
      int unsigned line_age   [SETS][WAYS];

      dir_result_t pending_responses[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
         foreach (line_valid[s, w]) begin
            line_valid[s][w] = 1'b0;
            line_dirty[s][w] = 1'b0;
            line_tag[s][w]   = 0;
            line_age[s][w]   = 0;
         end
      endfunction

      // make way w of the set most recently used; ages of valid ways stay 0..v-1
      function void promote(int unsigned set_idx, int unsigned w, bit was_valid);
         int unsigned old_age;
         int unsigned live;
         int unsigned k;
         old_age = line_age[set_idx][w];
         live    = 0;
         for (k = 0; k < WAYS; k++) begin
            if (line_valid[set_idx][k]) begin
               live++;
               if (was_valid && k != w && line_age[set_idx][k] > old_age)
                  line_age[set_idx][k]--;
            end
         end
         line_age[set_idx][w] = live - 1;
      endfunction

      // accepted request transaction: update the shadow and queue the expected response
      function void apply_access(logic kind, logic [ADDR_W-1:0] addr, logic fill_dirty);
         int unsigned set_idx;
         int unsigned tag;
         int unsigned w;
         int unsigned victim;
         dir_result_t res;
         set_idx      = addr % SETS;
         tag          = addr / SETS;
         res.req_addr = addr;
         res.hit      = 1'b0;
         res.way      = '0;
         res.wb_valid = 1'b0;
         res.wb_addr  = '0;

         for (w = 0; w < WAYS; w++)
            if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag) break;

         if (w < WAYS) begin
            res.hit = 1'b1;
            res.way = WAY_OUT_W'(w);
            if (kind == KIND_FILL) line_dirty[set_idx][w] = fill_dirty;
            promote(set_idx, w, 1'b1);
         end else if (kind == KIND_FILL) begin
            for (w = 0; w < WAYS; w++)
               if (!line_valid[set_idx][w]) break;
            if (w < WAYS) begin
               line_valid[set_idx][w] = 1'b1;
               line_dirty[set_idx][w] = fill_dirty;
               line_tag[set_idx][w]   = tag;
               promote(set_idx, w, 1'b0);
            end else begin
               // full set: evict the oldest line, way 0 if none has age zero
               victim = 0;
               for (w = 0; w < WAYS; w++) begin
                  if (line_age[set_idx][w] == 0) begin
                     victim = w;
                     break;
                  end
               end
               if (line_dirty[set_idx][victim]) begin
                  res.wb_valid = 1'b1;
                  res.wb_addr  = ADDR_W'(line_tag[set_idx][victim] * SETS + set_idx);
               end
               line_dirty[set_idx][victim] = fill_dirty;
               line_tag[set_idx][victim]   = tag;
               promote(set_idx, victim, 1'b1);
               w = victim;
            end
            res.way = WAY_OUT_W'(w);
         end
         pending_responses.push_back(res);
      endfunction

      function int unsigned outstanding();
         return pending_responses.size();
      endfunction

      // accepted response transaction: compare with the oldest expectation
      function void check_response(logic [RSP_DATA_W-1:0] data);
         dir_result_t exp_res;
         logic                 got_hit;
         logic [WAY_OUT_W-1:0] got_way;
         logic                 got_wb;
         logic [ADDR_W-1:0]    got_addr;
         logic [RSP_DATA_W-36:0] got_pad;
         got_hit  = data[0];
         got_way  = data[2:1];
         got_wb   = data[3];
         got_addr = data[34:4];
         got_pad  = data[RSP_DATA_W-1:35];

         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response transaction: data=%h", data);
            return;
         end
         exp_res = pending_responses.pop_front();
         if (got_hit !== exp_res.hit || got_way !== exp_res.way ||
             got_wb !== exp_res.wb_valid || got_addr !== exp_res.wb_addr ||
             got_pad !== '0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch addr=%h: exp hit=%0d way=%0d wb=%0d wb_addr=%h, got hit=%0d way=%0d wb=%0d wb_addr=%h pad=%h",
                        exp_res.req_addr, exp_res.hit, exp_res.way, exp_res.wb_valid,
                        exp_res.wb_addr, got_hit, got_way, got_wb, got_addr, got_pad);
         end
      endfunction

   endclass

endpackage

[tb/sv/tb_set_assoc_cache_directory_lru.sv]
// Testbench top: drives lookup and fill transactions into the cache directory and checks responses.
module tb_set_assoc_cache_directory_lru;

   timeunit 1ns;
   timeprecision 1ps;

   import sacd_pkg::*;
   import directory_shadow_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;  // watchdog limit for the whole run
   localparam int SETTLE_CYCLES = 60;      // longer than one unstalled transaction
   localparam int RANDOM_ITEMS  = 1080;
   localparam int HOLD_AFTER    = 300;     // responses seen before the long receiver stall
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_AT      = 700;     // random item where the sender waits for a drain
   localparam int TAG_MAX       = int'((longint'(1) << ADDR_W) / SETS - 1);
   localparam int LAST_SET      = SETS - 1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = KIND_LOOKUP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   directory_shadow shadow = new();

   int unsigned cycle_count = 0;
   int unsigned rsp_count   = 0;

   // small pools of tags and sets so lookups hit and fills evict often
   int unsigned       hot_tags [8];
   int unsigned       hot_sets [4];
   logic [ADDR_W-1:0] recent_fills[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   set_assoc_cache_directory_lru #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response monitor: values read here are the ones before this edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         shadow.check_response(rsp_tdata);
         rsp_count++;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [ADDR_W-1:0] make_address(int unsigned tag, int unsigned set_idx);
      return ADDR_W'(tag * SETS + set_idx);
   endfunction

   // extremes always stay in the pools; the rest is redrawn
   function automatic void refresh_hot_pools();
      hot_tags[0] = 0;
      hot_tags[1] = TAG_MAX;
      for (int i = 2; i < 8; i++) hot_tags[i] = $urandom_range(0, TAG_MAX);
      hot_sets[0] = 0;
      hot_sets[1] = LAST_SET;
      hot_sets[2] = $urandom_range(0, LAST_SET);
      hot_sets[3] = $urandom_range(0, LAST_SET);
   endfunction

   // offer one request transaction and hold it until the block takes it
   task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                               input logic dirty);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {dirty, addr};
      do @(posedge clock); while (!req_tready);
      shadow.apply_access(kind, addr, dirty);
      if (kind == KIND_FILL) begin
         recent_fills.push_back(addr);
         if (recent_fills.size() > 16) void'(recent_fills.pop_front());
      end
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles == 0) return;
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // receiver pacing, with one long stall that backs the block up
   initial begin : response_pacing
      int unsigned stall;
      int unsigned stretch;
      bit          held;
      held = 1'b0;
      @(negedge clock);
      forever begin
         if (!held && rsp_count >= HOLD_AFTER) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = pick_gap();
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 8);
         repeat (stretch) @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned       r;
      int unsigned       burst_left;
      logic              kind;
      logic [ADDR_W-1:0] addr;
      burst_left = 0;
      refresh_hot_pools();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // the clearing pass keeps req_tready low; send_request just waits it out

      // --- directed: misses at the address extremes, then one set walked through
      //     invalid fills, a hit, a matching fill, dirty and clean evictions
      send_request(KIND_LOOKUP, '0, 1'b0);
      send_request(KIND_LOOKUP, '1, 1'b1);
      send_request(KIND_FILL, make_address(TAG_MAX, LAST_SET), 1'b1);
      send_request(KIND_FILL, make_address(0, LAST_SET), 1'b0);
      send_request(KIND_FILL, make_address(1, LAST_SET), 1'b0);
      send_request(KIND_FILL, make_address(2, LAST_SET), 1'b0);
      send_request(KIND_LOOKUP, make_address(0, LAST_SET), 1'b0);
      send_request(KIND_FILL, make_address(1, LAST_SET), 1'b1);  // matching way turns dirty
      send_request(KIND_FILL, make_address(3, LAST_SET), 1'b0);  // evicts dirty all-ones line
      send_request(KIND_FILL, make_address(4, LAST_SET), 1'b1);  // clean victim
      send_request(KIND_LOOKUP, make_address(TAG_MAX, LAST_SET), 1'b0);
      send_request(KIND_FILL, make_address(5, LAST_SET), 1'b0);
      send_request(KIND_FILL, make_address(6, LAST_SET), 1'b0);
      send_request(KIND_FILL, make_address(7, LAST_SET), 1'b1);
      send_request(KIND_FILL, '0, 1'b1);
      send_request(KIND_LOOKUP, '0, 1'b0);
      send_request(KIND_FILL, '0, 1'b0);                         // matching fill clears dirty
      send_request(KIND_FILL, make_address(TAG_MAX, 0), 1'b1);
      send_request(KIND_LOOKUP, 31'h5555_5555, 1'b0);
      send_request(KIND_LOOKUP, 31'h2AAA_AAAA, 1'b1);

      // --- random: mostly hot sets and tags, some replays of recent fills, some noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == DRAIN_AT) wait_drained();
         if (n % 250 == 249) refresh_hot_pools();

         if (burst_left != 0) begin
            burst_left--;
         end else if ($urandom_range(0, 99) < 4) begin
            burst_left = 40;
         end else begin
            pause_sender(pick_gap());
         end

         r = $urandom_range(0, 99);
         if (r < 10)
            addr = ADDR_W'($urandom());
         else if (r < 25 && recent_fills.size() != 0)
            addr = recent_fills[$urandom_range(0, recent_fills.size() - 1)];
         else
            addr = make_address(hot_tags[$urandom_range(0, 7)], hot_sets[$urandom_range(0, 3)]);
         kind = ($urandom_range(0, 99) < 45) ? KIND_FILL : KIND_LOOKUP;
         send_request(kind, addr, 1'($urandom_range(0, 1)));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
